// ===== design/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, constants and codes for the four-level page-table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

    // default number of 4 KiB table pages held in table memory
    localparam int TABLE_PAGES_DEF = 64;

    localparam int ENTRY_W   = 64;
    localparam int IDX_W     = 9;
    localparam int ENTRIES   = 512;
    localparam int VA_W      = 48;
    localparam int PA_W      = 52;
    localparam int FLAGS_W   = 12;
    localparam int PAGE_SH   = 12;
    localparam int LINK_W    = PA_W - PAGE_SH;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;

    // index field positions, top level first
    localparam int SHIFT_L0 = 39;
    localparam int SHIFT_L1 = 30;
    localparam int SHIFT_L2 = 21;
    localparam int SHIFT_L3 = 12;

    localparam logic [ENTRY_W-1:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;
    localparam logic [ENTRY_W-1:0] LINK_FLAGS = 64'h7;
    localparam logic [ENTRY_W-1:0] PRESENT    = 64'h1;

    localparam logic [1:0] LEAF_LEVEL = 2'd3;

    // operation codes
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_MAP    = 2'd1;
    localparam logic [1:0] MODE_UNMAP  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL = 2'd1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_UNMAPPED = 2'd1,
        STATUS_NOPAGES  = 2'd2
    } ptw_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_PGCLR,
        ST_LINK,
        ST_DONE
    } ptw_state_t;

    // controller -> datapath
    typedef struct packed {
        logic        accept;     // latch request, start at root
        logic        rd_issue;   // read entry at current page/level
        logic        follow;     // take link from entry, next level
        logic        alloc;      // grab next free page
        logic        clr_wr;     // write zero at clear address
        logic        clr_full;   // clear address is the whole store
        logic        link_wr;    // link new page into current entry
        logic        leaf_wr;    // map or unmap write at leaf
        logic        res_load;
        ptw_status_t res_status;
        logic        res_frame;  // result carries the leaf frame
        logic        out_load;
    } ptw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic page_bad;
        logic present;
        logic last_level;
        logic is_map;
        logic is_unmap;
        logic pool_empty;
        logic clr_last_full;
        logic clr_last_page;
    } ptw_stat_t;

endpackage

// ===== design/ptw_ifs.sv =====
// ----------------------------------------------------------------------------
// ptw_req_if / ptw_rsp_if
// Valid/ready channels for walker requests and results.
// ----------------------------------------------------------------------------
interface ptw_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [47:0] virt_addr;
    logic [51:0] phys_addr;
    logic [11:0] page_flags;

    modport source (output valid, output mode, output virt_addr, output phys_addr,
                    output page_flags, input ready);
    modport sink   (input valid, input mode, input virt_addr, input phys_addr,
                    input page_flags, output ready);
endinterface

interface ptw_rsp_if;
    logic        valid;
    logic        ready;
    logic [51:0] frame_addr;
    logic [1:0]  status;

    modport source (output valid, output frame_addr, output status, input ready);
    modport sink   (input valid, input frame_addr, input status, output ready);
endinterface

// ===== design/ptw_ram.sv =====
// ----------------------------------------------------------------------------
// ptw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ptw_datapath.sv =====
// ----------------------------------------------------------------------------
// ptw_datapath
// Request registers, walk pointer, allocator, clear counter, table memory
// and result registers.
// ----------------------------------------------------------------------------
module ptw_datapath #(
    parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptw_pkg::ptw_cmd_t             cmd,
    output ptw_pkg::ptw_stat_t            stat,
    input  logic [1:0]                    req_mode,
    input  logic [ptw_pkg::VA_W-1:0]      req_virt_addr,
    input  logic [ptw_pkg::PA_W-1:0]      req_phys_addr,
    input  logic [ptw_pkg::FLAGS_W-1:0]   req_page_flags,
    input  logic                          cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [ptw_pkg::CFG_W-1:0]     cfg_data,
    output logic [ptw_pkg::PA_W-1:0]      rsp_frame_addr,
    output logic [1:0]                    rsp_status
);

    localparam int PAGE_W  = $clog2(TABLE_PAGES);
    localparam int ADDR_W  = PAGE_W + ptw_pkg::IDX_W;
    localparam int DEPTH   = TABLE_PAGES * ptw_pkg::ENTRIES;
    localparam int NFP_W   = (PAGE_W + 1 > ptw_pkg::CFG_W) ? PAGE_W + 1 : ptw_pkg::CFG_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ptw_pkg::IDX_W-1:0] LAST_IDX = ptw_pkg::IDX_W'(ptw_pkg::ENTRIES - 1);

    logic [1:0]                  mode_reg;
    logic [ptw_pkg::VA_W-1:0]    va_reg;
    logic [ptw_pkg::PA_W-1:0]    pa_reg;
    logic [ptw_pkg::FLAGS_W-1:0] flags_reg;
    logic [PAGE_W-1:0]           page_reg;
    logic                        page_bad_reg;
    logic [1:0]                  level_reg;
    logic [PAGE_W-1:0]           np_reg;
    logic [ADDR_W-1:0]           clr_cnt_reg;
    logic [ptw_pkg::CFG_W-1:0]   root_reg;
    logic [NFP_W-1:0]            nfp_reg;
    logic [1:0]                  res_status_reg;
    logic [ptw_pkg::PA_W-1:0]    res_frame_reg;
    logic [1:0]                  out_status_reg;
    logic [ptw_pkg::PA_W-1:0]    out_frame_reg;

    logic [ptw_pkg::IDX_W-1:0]   idx;
    logic [ADDR_W-1:0]           entry_addr;
    logic [ptw_pkg::ENTRY_W-1:0] rd_data;
    logic [ptw_pkg::LINK_W-1:0]  link_page;
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [ptw_pkg::ENTRY_W-1:0] ram_wdata;
    logic [ptw_pkg::ENTRY_W-1:0] map_entry;
    logic [ptw_pkg::ENTRY_W-1:0] link_entry;

    // index field for the current level
    always_comb
    begin
        case (level_reg)
            2'd0:    idx = va_reg[ptw_pkg::SHIFT_L0 +: ptw_pkg::IDX_W];
            2'd1:    idx = va_reg[ptw_pkg::SHIFT_L1 +: ptw_pkg::IDX_W];
            2'd2:    idx = va_reg[ptw_pkg::SHIFT_L2 +: ptw_pkg::IDX_W];
            default: idx = va_reg[ptw_pkg::SHIFT_L3 +: ptw_pkg::IDX_W];
        endcase
    end

    assign entry_addr = {page_reg, idx};
    assign link_page  = rd_data[ptw_pkg::PA_W-1:ptw_pkg::PAGE_SH];
    assign map_entry  = (ptw_pkg::ENTRY_W'(pa_reg) & ptw_pkg::FRAME_MASK)
                      | ptw_pkg::ENTRY_W'(flags_reg) | ptw_pkg::PRESENT;
    assign link_entry = (ptw_pkg::ENTRY_W'(np_reg) << ptw_pkg::PAGE_SH) | ptw_pkg::LINK_FLAGS;

    // write port: clear sweep, link or leaf update
    always_comb
    begin
        ram_we    = cmd.clr_wr | cmd.link_wr | cmd.leaf_wr;
        ram_waddr = entry_addr;
        ram_wdata = '0;
        if (cmd.clr_wr)
        begin
            ram_waddr = cmd.clr_full ? clr_cnt_reg
                                     : {np_reg, clr_cnt_reg[ptw_pkg::IDX_W-1:0]};
        end
        else if (cmd.link_wr)
        begin
            ram_wdata = link_entry;
        end
        else if (stat.is_map)
        begin
            ram_wdata = map_entry;
        end
    end

    ptw_ram #(
        .WIDTH (ptw_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_issue),
        .raddr (entry_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        stat.page_bad      = page_bad_reg;
        stat.present       = rd_data[0];
        stat.last_level    = (level_reg == ptw_pkg::LEAF_LEVEL);
        stat.is_map        = (mode_reg == ptw_pkg::MODE_MAP);
        stat.is_unmap      = (mode_reg == ptw_pkg::MODE_UNMAP);
        stat.pool_empty    = (nfp_reg >= NFP_W'(TABLE_PAGES));
        stat.clr_last_full = (clr_cnt_reg == LAST_ADDR);
        stat.clr_last_page = (clr_cnt_reg[ptw_pkg::IDX_W-1:0] == LAST_IDX);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg     <= '0;
            nfp_reg      <= NFP_W'(1);
            clr_cnt_reg  <= '0;
            level_reg    <= '0;
            page_bad_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_idx == ptw_pkg::CFG_ROOT)
            begin
                root_reg <= cfg_data;
            end
            if (cfg_we && cfg_idx == ptw_pkg::CFG_POOL)
            begin
                nfp_reg <= NFP_W'(cfg_data);
            end
            else if (cmd.alloc)
            begin
                nfp_reg <= nfp_reg + 1'b1;
            end

            if (cmd.alloc)
            begin
                clr_cnt_reg <= '0;
            end
            else if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end

            if (cmd.accept)
            begin
                level_reg    <= '0;
                page_bad_reg <= (NFP_W'(root_reg) >= NFP_W'(TABLE_PAGES));
            end
            else if (cmd.follow)
            begin
                level_reg    <= level_reg + 1'b1;
                page_bad_reg <= (link_page >= ptw_pkg::LINK_W'(TABLE_PAGES));
            end
            else if (cmd.link_wr)
            begin
                level_reg    <= level_reg + 1'b1;
                page_bad_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg  <= req_mode;
            va_reg    <= req_virt_addr;
            pa_reg    <= req_phys_addr;
            flags_reg <= req_page_flags;
            page_reg  <= PAGE_W'(root_reg);
        end
        else if (cmd.follow)
        begin
            page_reg <= PAGE_W'(link_page);
        end
        else if (cmd.link_wr)
        begin
            page_reg <= np_reg;
        end

        if (cmd.alloc)
        begin
            np_reg <= PAGE_W'(nfp_reg);
        end

        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_frame_reg  <= cmd.res_frame
                            ? rd_data[ptw_pkg::PA_W-1:0] & ptw_pkg::FRAME_MASK[ptw_pkg::PA_W-1:0]
                            : '0;
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_frame_reg  <= res_frame_reg;
        end
    end

    assign rsp_frame_addr = out_frame_reg;
    assign rsp_status     = out_status_reg;

    a_alloc_bumps: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc && !(cfg_we && cfg_idx == ptw_pkg::CFG_POOL)
        |=> nfp_reg == $past(nfp_reg) + 1'b1)
        else $error("allocator did not advance by one page");

    a_alloc_has_page: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> !stat.pool_empty)
        else $error("page taken from an empty pool");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> !page_bad_reg)
        else $error("table read from a page outside table memory");

    a_leaf_at_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.leaf_wr |-> level_reg == ptw_pkg::LEAF_LEVEL)
        else $error("leaf write above the last level");

endmodule

// ===== design/ptw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptw_ctrl
// Walk sequencer: reset clear, per-level read/evaluate, table creation,
// result hand-off to the output register.
// ----------------------------------------------------------------------------
module ptw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ptw_pkg::ptw_stat_t stat,
    output ptw_pkg::ptw_cmd_t  cmd
);

    ptw_pkg::ptw_state_t state_reg;
    ptw_pkg::ptw_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptw_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = ptw_pkg::STATUS_OK;
        in_ready       = 1'b0;

        case (state_reg)
            ptw_pkg::ST_CLEAR:
            begin
                cmd.clr_wr   = 1'b1;
                cmd.clr_full = 1'b1;
                if (stat.clr_last_full)
                begin
                    state_next = ptw_pkg::ST_IDLE;
                end
            end
            ptw_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ptw_pkg::ST_READ;
                end
            end
            ptw_pkg::ST_READ:
            begin
                if (stat.page_bad)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ptw_pkg::STATUS_UNMAPPED;
                    state_next     = ptw_pkg::ST_DONE;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ptw_pkg::ST_EVAL;
                end
            end
            ptw_pkg::ST_EVAL:
            begin
                if (stat.last_level)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ptw_pkg::ST_DONE;
                    if (stat.is_map)
                    begin
                        cmd.leaf_wr = 1'b1;
                    end
                    else if (!stat.present)
                    begin
                        cmd.res_status = ptw_pkg::STATUS_UNMAPPED;
                    end
                    else if (stat.is_unmap)
                    begin
                        cmd.leaf_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.res_frame = 1'b1;
                    end
                end
                else if (stat.present)
                begin
                    cmd.follow = 1'b1;
                    state_next = ptw_pkg::ST_READ;
                end
                else if (!stat.is_map)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ptw_pkg::STATUS_UNMAPPED;
                    state_next     = ptw_pkg::ST_DONE;
                end
                else if (stat.pool_empty)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ptw_pkg::STATUS_NOPAGES;
                    state_next     = ptw_pkg::ST_DONE;
                end
                else
                begin
                    cmd.alloc  = 1'b1;
                    state_next = ptw_pkg::ST_PGCLR;
                end
            end
            ptw_pkg::ST_PGCLR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last_page)
                begin
                    state_next = ptw_pkg::ST_LINK;
                end
            end
            ptw_pkg::ST_LINK:
            begin
                cmd.link_wr = 1'b1;
                state_next  = ptw_pkg::ST_READ;
            end
            ptw_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ptw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ptw_pkg::ST_CLEAR |=> state_reg != ptw_pkg::ST_CLEAR)
        else $error("reset clear pass entered again");

    a_pgclr_to_link: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ptw_pkg::ST_LINK |-> $past(state_reg) == ptw_pkg::ST_PGCLR)
        else $error("link written without a page clear");

endmodule

// ===== design/four_level_page_table_walker.sv =====
// Walk: with all tables present, each level takes a read state and an evaluate
//   state, then the result is handed off through the output register.
// One walk at a time: a new request is taken only after the previous one is handed off;
//   each table created by a map adds a 512-entry page clear through the single RAM write port + link.
// Reset: a clearing pass writes zero to all TABLE_PAGES*512 entries with req.ready low;
//   config is taken meanwhile.
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level page-table walker over a local table memory: lookup, map with
// table creation from a bump allocator, and unmap.
// ----------------------------------------------------------------------------
module four_level_page_table_walker #(
    parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ptw_req_if.sink                       req,
    ptw_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [ptw_pkg::CFG_W-1:0]     cfg_data
);

    // Controller/datapath split: the controller owns sequencing and the
    // output valid flag; the datapath owns every payload register and the
    // table memory. They talk only through cmd/stat.
    ptw_pkg::ptw_cmd_t  cmd;
    ptw_pkg::ptw_stat_t stat;

    // Sequencer. One walk at a time; the output register lets the next
    // item be accepted while the previous result waits on rsp.ready.
    ptw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: table memory (1 write + 1 registered read port), the walk
    // pointer, the allocator and the root/pool configuration registers.
    // Writing the pool register reloads the allocator immediately.
    ptw_datapath #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_mode       (req.mode),
        .req_virt_addr  (req.virt_addr),
        .req_phys_addr  (req.phys_addr),
        .req_page_flags (req.page_flags),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_data       (cfg_data),
        .rsp_frame_addr (rsp.frame_addr),
        .rsp_status     (rsp.status)
    );

endmodule

// ===== bench/ptw_walk_checker.sv =====
// ----------------------------------------------------------------------------
// ptw_walk_checker
// Watches the request, result and config channels of the page-table walker,
// keeps its own copy of the table memory and allocator, predicts each result
// at accept time and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module ptw_walk_checker #(
    parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ptw_req_if                            req,
    ptw_rsp_if                            rsp,
    input  logic                          cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [ptw_pkg::CFG_W-1:0]     cfg_data,
    output int                            errors,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROOT_AT_RESET = 0;
    localparam int POOL_AT_RESET = 1;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [ptw_pkg::PA_W-1:0] frame;
        ptw_pkg::ptw_status_t     status;
    } walk_result_t;

    logic [ptw_pkg::ENTRY_W-1:0] table_mem [TABLE_PAGES*ptw_pkg::ENTRIES];
    logic [63:0]                 root_page;
    int unsigned                 next_page;
    walk_result_t                results_due [$];
    int                          mismatches;

    // descend three link levels; allocate missing tables when building
    function automatic bit walk_to_leaf(input logic [ptw_pkg::VA_W-1:0] va,
                                        input bit build,
                                        output int leaf,
                                        output ptw_pkg::ptw_status_t st);
        logic [63:0] page;
        int          slot;
        int          lvl;
        int          i;
        leaf = 0;
        st   = ptw_pkg::STATUS_OK;
        page = root_page;
        if (page >= 64'(TABLE_PAGES))
        begin
            st = ptw_pkg::STATUS_UNMAPPED;
            return 1'b0;
        end
        for (lvl = 0; lvl < 3; lvl++)
        begin
            slot = int'(page[15:0]) * ptw_pkg::ENTRIES
                 + int'(va[ptw_pkg::SHIFT_L0 - ptw_pkg::IDX_W*lvl +: ptw_pkg::IDX_W]);
            if (!table_mem[slot][0])
            begin
                if (!build)
                begin
                    st = ptw_pkg::STATUS_UNMAPPED;
                    return 1'b0;
                end
                if (next_page >= TABLE_PAGES)
                begin
                    st = ptw_pkg::STATUS_NOPAGES;
                    return 1'b0;
                end
                // clear first: the new page may hold the slot being linked
                for (i = 0; i < ptw_pkg::ENTRIES; i++)
                    table_mem[int'(next_page) * ptw_pkg::ENTRIES + i] = '0;
                table_mem[slot] = (64'(next_page) << ptw_pkg::PAGE_SH) | ptw_pkg::LINK_FLAGS;
                next_page++;
            end
            page = (table_mem[slot] & ptw_pkg::FRAME_MASK) >> ptw_pkg::PAGE_SH;
            if (page >= 64'(TABLE_PAGES))
            begin
                st = ptw_pkg::STATUS_UNMAPPED;
                return 1'b0;
            end
        end
        leaf = int'(page[15:0]) * ptw_pkg::ENTRIES
             + int'(va[ptw_pkg::SHIFT_L3 +: ptw_pkg::IDX_W]);
        return 1'b1;
    endfunction

    // one request -> one result; updates the table copy as the block would
    function automatic walk_result_t predict_walk(input logic [1:0] mode,
                                                  input logic [ptw_pkg::VA_W-1:0] va,
                                                  input logic [ptw_pkg::PA_W-1:0] pa,
                                                  input logic [ptw_pkg::FLAGS_W-1:0] flags);
        walk_result_t         res;
        ptw_pkg::ptw_status_t st;
        int                   leaf;
        bit                   found;
        res.frame = '0;
        found = walk_to_leaf(va, mode == ptw_pkg::MODE_MAP, leaf, st);
        if (found)
        begin
            if (mode == ptw_pkg::MODE_MAP)
                table_mem[leaf] = ({12'h000, pa} & ptw_pkg::FRAME_MASK) | 64'(flags)
                                | ptw_pkg::PRESENT;
            else if (!table_mem[leaf][0])
                st = ptw_pkg::STATUS_UNMAPPED;
            else if (mode == ptw_pkg::MODE_UNMAP)
                table_mem[leaf] = '0;
            else
                res.frame = table_mem[leaf][ptw_pkg::PA_W-1:0]
                          & ptw_pkg::FRAME_MASK[ptw_pkg::PA_W-1:0];
        end
        res.status = st;
        return res;
    endfunction

    function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        if (mismatches < REPORT_MAX)
            $display("[%0t] %s mismatch: expected %h, got %h", $time, what, want, got);
        mismatches++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t want;
        int           k;
        if (!rst_n)
        begin
            for (k = 0; k < TABLE_PAGES*ptw_pkg::ENTRIES; k++)
                table_mem[k] = '0;
            root_page  = 64'(ROOT_AT_RESET);
            next_page  = POOL_AT_RESET;
            mismatches = 0;
            results_due.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == ptw_pkg::CFG_ROOT)
                    root_page = 64'(cfg_data);
                else if (cfg_idx == ptw_pkg::CFG_POOL)
                    next_page = 32'(cfg_data);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (results_due.size() == 0)
                    flag_mismatch("unrequested result", '0,
                                  {10'h000, rsp.status, rsp.frame_addr});
                else
                begin
                    want = results_due.pop_front();
                    if (rsp.frame_addr !== want.frame)
                        flag_mismatch("frame_addr", 64'(want.frame), 64'(rsp.frame_addr));
                    if (rsp.status !== want.status)
                        flag_mismatch("status", 64'(want.status), 64'(rsp.status));
                end
            end
            if (req.valid && req.ready)
                results_due.push_back(predict_walk(req.mode, req.virt_addr,
                                                   req.phys_addr, req.page_flags));
            errors  <= mismatches;
            pending <= results_due.size();
        end
    end

endmodule

// ===== bench/four_level_page_table_walker_tb.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker_tb
// Drives lookups, maps and unmaps into the walker under several root/pool
// settings, with random stalls on both channels; a side checker predicts
// every result and this top reports the verdict.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGES       = ptw_pkg::TABLE_PAGES_DEF;
    // slow case: the clearing pass, up to 64 page clears per setting,
    // every item with the longest gaps on both sides; then several times that
    localparam int CYCLE_CAP   = 2_000_000;
    localparam int PHASE_ITEMS = 290;
    localparam int KNOWN_MAX   = 48;
    localparam int SETTLE      = 30;

    // mode 3 is not defined; the block walks it as a lookup
    localparam logic [1:0] MODE_SPARE = 2'd3;
    // register indexes past the list; writes there must do nothing
    localparam logic [ptw_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam int unsigned                   CFG_UNUSED_B = 3;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [ptw_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [ptw_pkg::CFG_W-1:0]     cfg_data;
    int                            errors;
    int                            pending;

    // calm: a stretch where neither side idles
    logic                          calm;
    int unsigned                   rsp_hold;
    // addresses mapped recently, reused for lookups and unmaps
    logic [ptw_pkg::VA_W-1:0]      known_va [$];

    ptw_req_if req();
    ptw_rsp_if rsp();

    four_level_page_table_walker #(
        .TABLE_PAGES (PAGES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    ptw_walk_checker #(
        .TABLE_PAGES (PAGES)
    ) walk_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ptw_pkg::VA_W-1:0] make_va(
        input logic [ptw_pkg::IDX_W-1:0] l0,
        input logic [ptw_pkg::IDX_W-1:0] l1,
        input logic [ptw_pkg::IDX_W-1:0] l2,
        input logic [ptw_pkg::IDX_W-1:0] l3);
        return {l0, l1, l2, l3, 12'h000};
    endfunction

    // alternate between calm stretches and stretches with idling
    initial
    begin
        calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(150, 600)) @(posedge clk);
            calm <= ~calm;
        end
    end

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_hold  <= 0;
        end
        else if (rsp_hold != 0)
        begin
            rsp_hold <= rsp_hold - 1;
        end
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            rsp.ready <= 1'b0;
            rsp_hold  <= gap_len();
        end
        else
        begin
            rsp.ready <= 1'b1;
        end
    end

    // present one item and hold it until the block takes it
    task automatic send_item(input logic [1:0] mode, input logic [ptw_pkg::VA_W-1:0] va,
                             input logic [ptw_pkg::PA_W-1:0] pa,
                             input logic [ptw_pkg::FLAGS_W-1:0] flags);
        int unsigned gap;
        req.valid      <= 1'b1;
        req.mode       <= mode;
        req.virt_addr  <= va;
        req.phys_addr  <= pa;
        req.page_flags <= flags;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // caller drops cfg_we after the last write of a batch
    task automatic cfg_write(input logic [ptw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ptw_pkg::CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // One setting of root and pool, then random traffic. Most addresses sit
    // in a few subtrees so tables get reused and lookups hit; the rest is
    // fully random to push the allocator to exhaustion and miss at every level.
    task automatic run_random_phase(input logic [ptw_pkg::CFG_W-1:0] root,
                                    input logic [ptw_pkg::CFG_W-1:0] pool);
        logic [ptw_pkg::IDX_W-1:0] top_idx [2];
        logic [ptw_pkg::IDX_W-1:0] mid_idx [2];
        logic [ptw_pkg::IDX_W-1:0] low_idx [3];
        logic [63:0]               noise;
        logic [63:0]               wild;
        logic [ptw_pkg::VA_W-1:0]  va;
        logic [ptw_pkg::PA_W-1:0]  pa;
        logic [1:0]                mode;
        int unsigned               pick;
        drain_results();
        cfg_write(ptw_pkg::CFG_ROOT, root);
        cfg_write(ptw_pkg::CFG_POOL, pool);
        cfg_we <= 1'b0;
        foreach (top_idx[i])
            top_idx[i] = 9'($urandom_range(0, ptw_pkg::ENTRIES - 1));
        foreach (mid_idx[i])
            mid_idx[i] = 9'($urandom_range(0, ptw_pkg::ENTRIES - 1));
        foreach (low_idx[i])
            low_idx[i] = 9'($urandom_range(0, ptw_pkg::ENTRIES - 1));
        repeat (PHASE_ITEMS)
        begin
            noise = {$urandom(), $urandom()};
            wild  = {$urandom(), $urandom()};
            va = {top_idx[$urandom_range(0, 1)], mid_idx[$urandom_range(0, 1)],
                  low_idx[$urandom_range(0, 2)], noise[20:0]};
            // small frames double as table links once the root moves
            if ($urandom_range(0, 3) == 0)
                pa = {40'($urandom_range(0, PAGES - 1)), wild[63:52]};
            else
                pa = {noise[63:32], wild[51:32]};
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                mode = ptw_pkg::MODE_MAP;
                known_va.push_back(va);
                if (known_va.size() > KNOWN_MAX)
                    void'(known_va.pop_front());
            end
            else if (pick < 75 && known_va.size() != 0)
            begin
                va = known_va[$urandom_range(0, known_va.size() - 1)];
                mode = (pick < 55) ? ptw_pkg::MODE_LOOKUP
                     : (pick < 60) ? MODE_SPARE : ptw_pkg::MODE_UNMAP;
            end
            else if (pick < 88)
            begin
                mode = 2'($urandom_range(0, 3));
            end
            else
            begin
                mode = 2'($urandom_range(0, 3));
                va   = wild[47:0];
            end
            send_item(mode, va, pa, 12'($urandom_range(0, 4095)));
            // occasionally hold off until the pipe is empty
            if ($urandom_range(0, 99) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        repeat (CYCLE_CAP) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        req.valid      = 1'b0;
        req.mode       = ptw_pkg::MODE_LOOKUP;
        req.virt_addr  = '0;
        req.phys_addr  = '0;
        req.page_flags = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // clearing pass after reset keeps req.ready low
        @(posedge clk);
        while (!req.ready) @(posedge clk);

        // --- default root 0, pool 1 ---
        // nothing mapped yet: every walk stops at the root
        send_item(ptw_pkg::MODE_LOOKUP, '0, '0, '0);
        send_item(ptw_pkg::MODE_UNMAP, '0, '0, '0);
        send_item(MODE_SPARE, '1, '0, '0);
        // first map builds tables 1, 2, 3; widest frame and flags
        send_item(ptw_pkg::MODE_MAP, '0, '1, '1);
        send_item(ptw_pkg::MODE_LOOKUP, 48'h0000_0000_0FFF, '0, '0);  // offset bits ignored
        send_item(MODE_SPARE, '0, '1, '1);
        // top corner of the address space: tables 4, 5, 6, zero frame
        send_item(ptw_pkg::MODE_MAP, '1, '0, '0);
        send_item(ptw_pkg::MODE_LOOKUP, '1, '0, '0);
        send_item(ptw_pkg::MODE_UNMAP, '1, '0, '0);
        send_item(ptw_pkg::MODE_LOOKUP, '1, '0, '0);
        send_item(ptw_pkg::MODE_UNMAP, '1, '0, '0);   // leaf already clear
        // neighbors in the low leaf table; their frames point at pages 63 and 5
        send_item(ptw_pkg::MODE_MAP, make_va(9'd0, 9'd0, 9'd0, 9'd1), {40'd63, 12'hABC},
                  12'h002);
        send_item(ptw_pkg::MODE_MAP, make_va(9'd0, 9'd0, 9'd0, 9'd2), {40'd5, 12'h000},
                  12'h800);
        send_item(ptw_pkg::MODE_MAP, make_va(9'd1, 9'd0, 9'd0, 9'd0), 52'h1_2345_6789_A000,
                  12'h0F0);
        send_item(ptw_pkg::MODE_MAP, '0, 52'h5_5555_5555_5555, 12'hAAA);   // remap in place
        drain_results();

        // --- root moved onto page 3, the low leaf table ---
        // its entries now read as links: one out of range, one to 63, one to 5.
        // Writes to indexes past the register list go along and must be ignored.
        cfg_write(CFG_UNUSED_A, '1);
        cfg_write(ptw_pkg::CFG_IDX_W'(CFG_UNUSED_B), '0);
        cfg_write(ptw_pkg::CFG_ROOT, 6'd3);
        cfg_we <= 1'b0;
        send_item(ptw_pkg::MODE_LOOKUP, make_va(9'd0, 9'd4, 9'd4, 9'd4), '0, '0);
        // stops, writes nothing
        send_item(ptw_pkg::MODE_MAP, make_va(9'd0, 9'd4, 9'd4, 9'd4), '1, '1);
        send_item(ptw_pkg::MODE_UNMAP, make_va(9'd0, 9'd4, 9'd4, 9'd4), '0, '0);
        send_item(ptw_pkg::MODE_MAP, make_va(9'd1, 9'd5, 9'd7, 9'd9), 52'hA_BCDE_F012_3000,
                  12'h123);
        send_item(ptw_pkg::MODE_LOOKUP, make_va(9'd1, 9'd5, 9'd7, 9'd9), '0, '0);
        send_item(ptw_pkg::MODE_LOOKUP, make_va(9'd2, 9'h1FF, 9'h1FF, 9'h1FF), '0, '0);
        drain_results();

        // --- pool near the top: two tables, then the allocator runs dry ---
        cfg_write(ptw_pkg::CFG_ROOT, 6'd0);
        cfg_write(ptw_pkg::CFG_POOL, 6'd62);
        cfg_we <= 1'b0;
        send_item(ptw_pkg::MODE_MAP, make_va(9'd3, 9'd3, 9'd3, 9'd3), 52'h0_0000_0004_2000,
                  12'h004);
        send_item(ptw_pkg::MODE_LOOKUP, make_va(9'd3, 9'd3, 9'd3, 9'd3), '0, '0);
        send_item(ptw_pkg::MODE_MAP, make_va(9'd3, 9'd3, 9'd3, 9'd3), 52'h0_0000_0004_2000,
                  12'h004);
        drain_results();

        // --- extremes: root at the last page, pool from page 0 over live tables ---
        cfg_write(ptw_pkg::CFG_ROOT, 6'd63);
        cfg_write(ptw_pkg::CFG_POOL, 6'd0);
        cfg_we <= 1'b0;
        send_item(ptw_pkg::MODE_MAP, '0, 52'hF_0F0F_0F0F_0F0F, 12'h555);

        // --- random traffic under several settings ---
        run_random_phase(6'd0, 6'd1);
        run_random_phase(6'd63, 6'd0);
        run_random_phase(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        run_random_phase(6'd20, 6'd21);
        run_random_phase(6'd0, 6'd63);
        run_random_phase(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== four_level_page_table_walker.f =====
design/ptw_pkg.sv
design/ptw_ifs.sv
design/ptw_ram.sv
design/ptw_datapath.sv
design/ptw_ctrl.sv
design/four_level_page_table_walker.sv
bench/ptw_walk_checker.sv
bench/four_level_page_table_walker_tb.sv
